// ----- design/unc_pkg.sv -----
package unc_pkg;

	localparam int GRID_DEF = 64;
	localparam int ONE_Q14  = 16384;
	localparam int MAG_W    = 6;
	localparam int COMP_W   = 16;
	localparam int FRAC_W   = 14;
	localparam int FMAG_W   = 15;
	localparam int RAD_W    = 30;
	localparam int SQ_LAT   = 16;
	localparam int DIV_LAT  = 15;
	localparam int ROOT_AT  = SQ_LAT + 2;
	localparam int SIDE_N   = ROOT_AT + DIV_LAT;
	localparam int MAG_MAX  = 63;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] vec_z;
		logic [5:0]         code_mag_x;
		logic [5:0]         code_mag_y;
		logic               code_pos_x;
		logic               code_pos_y;
		logic               code_pos_z;
	} item_t;

	typedef struct packed {
		logic [5:0]         enc_mag_x;
		logic [5:0]         enc_mag_y;
		logic               enc_pos_x;
		logic               enc_pos_y;
		logic               enc_pos_z;
		logic signed [15:0] dec_x;
		logic signed [15:0] dec_y;
		logic signed [15:0] dec_z;
		logic               saturated;
	} result_t;

	// classified item as it waits between front and back
	typedef struct packed {
		logic              mode;
		logic [5:0]        enc_mag_x;
		logic [5:0]        enc_mag_y;
		logic              enc_pos_x;
		logic              enc_pos_y;
		logic              enc_pos_z;
		logic              sat;
		logic [FMAG_W-1:0] fx;
		logic [FMAG_W-1:0] fy;
		logic              pos_x;
		logic              pos_y;
		logic              pos_z;
	} front_t;

	typedef struct packed {
		front_t            f;
		logic              norm;
		logic [FMAG_W-1:0] root;
	} side_t;

endpackage

// ----- design/unc_front.sv -----
module unc_front import unc_pkg::*; #(
	parameter int GRID = GRID_DEF
) (
	input  item_t  item,
	output front_t cls
);

	localparam logic [7:0] GM1 = 8'(GRID - 1);
	localparam int LIM = (GRID - 1 > MAG_MAX) ? MAG_MAX : GRID - 1;
	localparam logic [10:0] LIM_V = 11'(LIM);

	logic [FMAG_W-1:0] fq_tab [64];
	logic [16:0] mag_x, mag_y;
	logic [24:0] prod_x, prod_y;
	logic [10:0] idx_x, idx_y;
	logic        sat_x, sat_y;

	// build the index to Q1.14 table, clamping indices above the grid
	for (genvar i = 0; i < 64; i++) begin : g_tab
		localparam int II = (i > GRID - 1) ? GRID - 1 : i;
		localparam int FV = (II * ONE_Q14 + (GRID - 1) / 2) / (GRID - 1);
		assign fq_tab[i] = FMAG_W'(FV);
	end

	// take magnitudes and scale onto the grid, rounding to nearest
	always_comb begin
		mag_x  = item.vec_x[15] ? 17'(17'h10000 - {1'b0, item.vec_x}) : {1'b0, item.vec_x};
		mag_y  = item.vec_y[15] ? 17'(17'h10000 - {1'b0, item.vec_y}) : {1'b0, item.vec_y};
		prod_x = 25'(mag_x) * 25'(GM1) + 25'(8192);
		prod_y = 25'(mag_y) * 25'(GM1) + 25'(8192);
		idx_x  = prod_x[24:14];
		idx_y  = prod_y[24:14];
		sat_x  = idx_x > LIM_V;
		sat_y  = idx_y > LIM_V;
	end

	// classify: encode fields are zero in decode mode
	always_comb begin
		cls.mode      = item.mode;
		cls.enc_mag_x = item.mode ? 6'd0 : (sat_x ? LIM_V[5:0] : idx_x[5:0]);
		cls.enc_mag_y = item.mode ? 6'd0 : (sat_y ? LIM_V[5:0] : idx_y[5:0]);
		cls.enc_pos_x = !item.mode && !item.vec_x[15];
		cls.enc_pos_y = !item.mode && !item.vec_y[15];
		cls.enc_pos_z = !item.mode && !item.vec_z[15];
		cls.sat       = !item.mode && (sat_x || sat_y);
		cls.fx        = fq_tab[item.code_mag_x];
		cls.fy        = fq_tab[item.code_mag_y];
		cls.pos_x     = item.code_pos_x;
		cls.pos_y     = item.code_pos_y;
		cls.pos_z     = item.code_pos_z;
	end

endmodule

// ----- design/unc_queue.sv -----
module unc_queue import unc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  front_t wdata,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output front_t head
);

	front_t     mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	// store the incoming transfer
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ----- design/unc_isqrt.sv -----
module unc_isqrt import unc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [FMAG_W-1:0] root
);

	logic [RAD_W-1:0]  n_in [15];
	logic [RAD_W-1:0]  r_in [15];
	logic [RAD_W-1:0]  n_q  [15];
	logic [RAD_W-1:0]  r_q  [15];
	logic [FMAG_W-1:0] root_q;

	// one result bit per stage, restoring form
	for (genvar j = 0; j < 15; j++) begin : g_st
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (28 - 2 * j);
		logic [RAD_W-1:0] t;
		logic             ge;
		if (j == 0) begin : g_first
			assign n_in[j] = rad;
			assign r_in[j] = '0;
		end else begin : g_next
			assign n_in[j] = n_q[j-1];
			assign r_in[j] = r_q[j-1];
		end
		assign t  = r_in[j] + BIT;
		assign ge = n_in[j] >= t;
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[j] <= ge ? n_in[j] - t : n_in[j];
				r_q[j] <= ge ? (r_in[j] >> 1) + BIT : r_in[j] >> 1;
			end
		end
	end

	// round to nearest from the remainder
	always_ff @(posedge clk) begin
		if (en) root_q <= FMAG_W'(r_q[14] + RAD_W'(n_q[14] > r_q[14]));
	end

	assign root = root_q;

endmodule

// ----- design/unc_div.sv -----
module unc_div import unc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  num,
	input  logic [FMAG_W-1:0] den,
	output logic [FMAG_W-1:0] quo
);

	logic [RAD_W-1:0]  rem_in [15];
	logic [FMAG_W-1:0] q_in   [15];
	logic [FMAG_W-1:0] d_in   [15];
	logic [RAD_W-1:0]  rem_q  [15];
	logic [FMAG_W-1:0] q_q    [15];
	logic [FMAG_W-1:0] d_q    [15];

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < 15; j++) begin : g_st
		localparam int K = 14 - j;
		logic [RAD_W-1:0] sh;
		logic             ge;
		if (j == 0) begin : g_first
			assign rem_in[j] = num;
			assign q_in[j]   = '0;
			assign d_in[j]   = den;
		end else begin : g_next
			assign rem_in[j] = rem_q[j-1];
			assign q_in[j]   = q_q[j-1];
			assign d_in[j]   = d_q[j-1];
		end
		assign sh = RAD_W'(d_in[j]) << K;
		assign ge = rem_in[j] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? rem_in[j] - sh : rem_in[j];
				q_q[j]   <= q_in[j] | (FMAG_W'(ge) << K);
				d_q[j]   <= d_in[j];
			end
		end
	end

	assign quo = q_q[14];

endmodule

// ----- design/unc_back.sv -----
module unc_back import unc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    head_valid,
	input  front_t  head,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * FRAC_W);

	logic                  adv;
	logic [SIDE_N-1:0]     vld_q;
	side_t                 side_q [SIDE_N];
	logic [2*FMAG_W-1:0]   sq_x_q, sq_y_q;
	logic [RAD_W-1:0]      n2, rad_q;
	logic                  norm;
	logic [FMAG_W-1:0]     root, qx, qy;
	logic [RAD_W-1:0]      num_x, num_y;
	logic                  res_valid_q;
	result_t               res_q;
	side_t                 last;
	logic [FMAG_W-1:0]     fxf, fyf, fzf;
	side_t                 side_norm, side_root;

	// the whole line moves while the output register is free or being taken
	assign adv = !res_valid_q || res_ready;
	assign pop = adv && head_valid;

	assign n2   = RAD_W'(sq_x_q) + RAD_W'(sq_y_q);
	assign norm = n2 > ONE_SQ;

	// advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[SIDE_N-2:0], head_valid};
			res_valid_q <= vld_q[SIDE_N-1];
		end
	end

	// attach the branch flag and the root to the records that pick them up
	always_comb begin
		side_norm      = side_q[0];
		side_norm.norm = norm;
		side_root      = side_q[ROOT_AT-1];
		side_root.root = root;
	end

	// squares, radicand and the side record of each item
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= '{f: head, norm: 1'b0, root: '0};
			sq_x_q    <= head.fx * head.fx;
			sq_y_q    <= head.fy * head.fy;
			side_q[1] <= side_norm;
			rad_q     <= norm ? n2 : ONE_SQ - n2;
			for (int i = 2; i < SIDE_N; i++) begin
				if (i == ROOT_AT) side_q[i] <= side_root;
				else side_q[i] <= side_q[i-1];
			end
		end
	end

	unc_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_q),
		.root (root)
	);

	// rounded dividend f * 2^14 + m/2
	assign num_x = RAD_W'({side_q[ROOT_AT-1].f.fx, {FRAC_W{1'b0}}}) + RAD_W'(root[FMAG_W-1:1]);
	assign num_y = RAD_W'({side_q[ROOT_AT-1].f.fy, {FRAC_W{1'b0}}}) + RAD_W'(root[FMAG_W-1:1]);

	unc_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (num_x),
		.den (root),
		.quo (qx)
	);

	unc_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (num_y),
		.den (root),
		.quo (qy)
	);

	// pick normalised or direct components
	assign last = side_q[SIDE_N-1];
	assign fxf  = last.norm ? qx : last.f.fx;
	assign fyf  = last.norm ? qy : last.f.fy;
	assign fzf  = last.norm ? '0 : last.root;

	// output register
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.enc_mag_x <= last.f.enc_mag_x;
			res_q.enc_mag_y <= last.f.enc_mag_y;
			res_q.enc_pos_x <= last.f.enc_pos_x;
			res_q.enc_pos_y <= last.f.enc_pos_y;
			res_q.enc_pos_z <= last.f.enc_pos_z;
			res_q.saturated <= last.f.sat;
			res_q.dec_x <= !last.f.mode ? '0 : last.f.pos_x ? COMP_W'(fxf) : COMP_W'(-{1'b0, fxf});
			res_q.dec_y <= !last.f.mode ? '0 : last.f.pos_y ? COMP_W'(fyf) : COMP_W'(-{1'b0, fyf});
			res_q.dec_z <= !last.f.mode ? '0 : last.f.pos_z ? COMP_W'(fzf) : COMP_W'(-{1'b0, fzf});
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- design/unit_normal_codec.sv -----
// Unit normal codec: encodes a Q1.14 vector to three sign bits and two grid indices, or
// decodes such a code back to a Q1.14 vector, one item per cycle through both valid/ready
// channels while results are taken. Every item, encode or decode, takes the same path: the
// queue stage, two squaring stages, the 16-stage square root pipeline and the 15-stage
// normalising divider of the decode path, plus the output register. A two-entry queue sits
// between the classifying front and the arithmetic back, and the back line only halts while
// its output register holds a result that has not been taken.
module unit_normal_codec import unc_pkg::*; #(
	parameter int GRID = GRID_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	front_t cls, head;
	logic   full, head_valid, pop;

	assign item_ready = !full;

	unc_front #(.GRID(GRID)) u_front (
		.item (item),
		.cls  (cls)
	);

	unc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_valid && !full),
		.wdata      (cls),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	unc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

// ----- bench/unit_normal_codec_check.sv -----
module unit_normal_codec_check import unc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    res_valid,
	input  logic    res_ready,
	input  result_t res,
	output int      errors,
	output int      pending
);

	localparam int GRID = GRID_DEF;

	result_t want_q[$];

	// rounded integer square root
	function automatic longint unsigned sqrt_near(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (n > r)
			r += 1;
		return r;
	endfunction

	function automatic longint unsigned grid_index(logic [15:0] v, ref bit sat);
		longint unsigned m, idx, lim;
		lim = (GRID - 1 > MAG_MAX) ? MAG_MAX : GRID - 1;
		m = v;
		if (v[15])
			m = (17'h10000 - m) & 17'h1FFFF;
		idx = (m * (GRID - 1) + 8192) >> 14;
		if (idx > lim) begin
			idx = lim;
			sat = 1;
		end
		return idx;
	endfunction

	function automatic longint unsigned index_q14(logic [5:0] i);
		longint unsigned d, x;
		d = GRID - 1;
		x = i;
		if (x > d)
			x = d;
		return (x * ONE_Q14 + d / 2) / d;
	endfunction

	function automatic logic [15:0] signed_comp(longint unsigned m, logic pos);
		logic [16:0] t;
		t = pos ? m[16:0] : 17'h10000 - m[16:0];
		return t[15:0];
	endfunction

	function automatic result_t codec_predict(item_t it);
		result_t r;
		bit sat;
		longint unsigned fx, fy, fz, n2, m;
		r = '0;
		sat = 0;
		if (!it.mode) begin
			r.enc_mag_x = 6'(grid_index(it.vec_x, sat));
			r.enc_mag_y = 6'(grid_index(it.vec_y, sat));
			r.enc_pos_x = !it.vec_x[15];
			r.enc_pos_y = !it.vec_y[15];
			r.enc_pos_z = !it.vec_z[15];
			r.saturated = sat;
		end else begin
			fx = index_q14(it.code_mag_x);
			fy = index_q14(it.code_mag_y);
			fz = 0;
			n2 = fx * fx + fy * fy;
			if (n2 <= 64'd268435456) begin
				fz = sqrt_near(64'd268435456 - n2);
			end else begin
				m = sqrt_near(n2);
				fx = (fx * ONE_Q14 + m / 2) / m;
				fy = (fy * ONE_Q14 + m / 2) / m;
			end
			r.dec_x = signed_comp(fx, it.code_pos_x);
			r.dec_y = signed_comp(fy, it.code_pos_y);
			r.dec_z = signed_comp(fz, it.code_pos_z);
		end
		return r;
	endfunction

	assign pending = want_q.size();

	// predict on input transfer, compare on output transfer
	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (item_valid && item_ready)
				want_q.push_back(codec_predict(item));
			if (res_valid && res_ready) begin
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res);
					errors <= errors + 1;
				end else begin
					w = want_q.pop_front();
					if (w !== res) begin
						$display("%0t: expected %h actual %h", $time, w, res);
						$display("  mag %0d/%0d %0d/%0d pos %b%b%b/%b%b%b",
							w.enc_mag_x, res.enc_mag_x, w.enc_mag_y, res.enc_mag_y,
							w.enc_pos_x, w.enc_pos_y, w.enc_pos_z,
							res.enc_pos_x, res.enc_pos_y, res.enc_pos_z);
						$display("  dec %0d,%0d,%0d / %0d,%0d,%0d sat %b/%b",
							w.dec_x, w.dec_y, w.dec_z, res.dec_x, res.dec_y, res.dec_z,
							w.saturated, res.saturated);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ----- bench/unit_normal_codec_test.sv -----
module unit_normal_codec_test;
	import unc_pkg::*;

	localparam int N_RAND = 1250;
	localparam int LIMIT  = 400000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    res_valid;
	logic    res_ready;
	result_t res;
	int      errors;
	int      pending;
	int      cycles;
	bit      calm;
	bit      hold_long;

	item_t directed[$];

	unit_normal_codec dut (.*);

	unit_normal_codec_check check (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_ready(item_ready),
		.item(item), .res_valid(res_valid), .res_ready(res_ready), .res(res),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// abort on a hung run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("unit_normal_codec_test: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'(-16384 + $urandom_range(0, 4));
			2: return 16'(16384 - $urandom_range(0, 4));
			3: return 16'($urandom_range(0, 3) - 1);
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it = item_t'({$urandom, $urandom});
		it.mode = 1'($urandom_range(0, 1));
		if (it.mode == 0) begin
			it.vec_x = rand_comp();
			it.vec_y = rand_comp();
			it.vec_z = rand_comp();
		end
		return it;
	endfunction

	function automatic item_t make_enc(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		item_t it;
		it = '0;
		it.vec_x = x;
		it.vec_y = y;
		it.vec_z = z;
		return it;
	endfunction

	function automatic item_t make_dec(logic [5:0] mx, logic [5:0] my, logic [2:0] p);
		item_t it;
		it = '0;
		it.mode = 1;
		it.code_mag_x = mx;
		it.code_mag_y = my;
		{it.code_pos_x, it.code_pos_y, it.code_pos_z} = p;
		return it;
	endfunction

	task automatic send(item_t it, bit idle_ok);
		int gap;
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			item_valid <= 0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int gap;
		res_ready <= 0;
		wait (arst_n);
		forever begin
			if (hold_long) begin
				res_ready <= 0;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				res_ready <= 0;
				gap = $urandom_range(1, 19);
				repeat (gap) @(posedge clk);
			end else begin
				res_ready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n = 0;
		item_valid = 0;
		item = '0;
		calm = 0;
		hold_long = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes, signs, zero, saturation, both decode branches
		directed.push_back(make_enc(16'h0000, 16'h0000, 16'h0000));
		directed.push_back(make_enc(16'd16384, 16'd16384, 16'd16384));
		directed.push_back(make_enc(-16'sd16384, -16'sd16384, -16'sd16384));
		directed.push_back(make_enc(16'h8000, 16'h8000, 16'h8000));
		directed.push_back(make_enc(16'h7FFF, 16'h0001, 16'hFFFF));
		directed.push_back(make_enc(16'd130, -16'sd130, 16'd0));
		directed.push_back(make_enc(16'hFFFF, 16'h7FFF, 16'h8000));
		directed.push_back(make_dec(6'd0, 6'd0, 3'b111));
		directed.push_back(make_dec(6'd0, 6'd0, 3'b000));
		directed.push_back(make_dec(6'd63, 6'd0, 3'b101));
		directed.push_back(make_dec(6'd0, 6'd63, 3'b010));
		directed.push_back(make_dec(6'd63, 6'd63, 3'b111));
		directed.push_back(make_dec(6'd63, 6'd63, 3'b000));
		directed.push_back(make_dec(6'd45, 6'd45, 3'b110));
		directed.push_back(make_dec(6'd44, 6'd44, 3'b011));
		directed.push_back(make_dec(6'd32, 6'd1, 3'b100));
		foreach (directed[i])
			send(directed[i], 1);

		// random stream
		for (int i = 0; i < N_RAND; i++) begin
			if (i == 300)
				hold_long = 1;
			if (i == 600) begin
				item_valid <= 0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			if (i == N_RAND - 150)
				calm = 1;
			send(rand_item(), !calm);
		end
		item_valid <= 0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("unit_normal_codec_test: PASS");
		else
			$display("unit_normal_codec_test: FAIL");
		$finish;
	end

endmodule
